[rtl/olte_pkg.sv]
// ----------------------------------------------------------------------------
// olte_pkg
// Shared types and constants for the ordered list table engine.
// ----------------------------------------------------------------------------
package olte_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 7;
  localparam int LEN_W     = 7;
  localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_DELETE = 3'd1;
  localparam logic [2:0] MODE_LOCATE = 3'd2;
  localparam logic [2:0] MODE_GET    = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [LEN_W-1:0]   found_position;
    logic [LEN_W-1:0]   list_length;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

[rtl/olte_ram.sv]
// ----------------------------------------------------------------------------
// olte_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olte_ram (
  input  logic              clk,
  input  olte_pkg::ram_req_t req,
  output olte_pkg::word_t   rdata
);

  olte_pkg::word_t mem [olte_pkg::DEPTH];
  olte_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/olte_ctrl.sv]
// ----------------------------------------------------------------------------
// olte_ctrl
// Sequencer: walks the store one entry per cycle to shift, compare or read.
// ----------------------------------------------------------------------------
module olte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  olte_pkg::in_t     in_item,
  output logic              busy,
  output logic              fin,
  output olte_pkg::out_t    result,
  output olte_pkg::ram_req_t ram_req,
  input  olte_pkg::word_t   ram_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } st_t;

  st_t                         st_r, st_nxt;
  logic [olte_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        iss_r, iss_nxt;
  logic                        pend_r, pend_nxt;
  logic                        plast_r, plast_nxt;
  logic [2:0]                  mode_r, mode_nxt;
  logic [olte_pkg::POS_W-1:0]  pos_r, pos_nxt;
  olte_pkg::word_t             val_r, val_nxt;
  logic [olte_pkg::ADDR_W-1:0] ra_r, ra_nxt;
  logic [olte_pkg::ADDR_W-1:0] rend_r, rend_nxt;
  logic [olte_pkg::ADDR_W-1:0] pa_r, pa_nxt;
  logic                        down_r, down_nxt;
  logic                        commit_r, commit_nxt;
  logic [1:0]                  status_r, status_nxt;
  olte_pkg::word_t             rd_r, rd_nxt;
  logic [olte_pkg::CNT_W-1:0]  found_r, found_nxt;

  logic [olte_pkg::CMP_W-1:0]  pos_x, cnt_x;
  logic [olte_pkg::ADDR_W-1:0] pos_m1, cnt_m1;

  assign pos_x  = olte_pkg::CMP_W'(in_item.position);
  assign cnt_x  = olte_pkg::CMP_W'(cnt_r);
  assign pos_m1 = olte_pkg::ADDR_W'(in_item.position - olte_pkg::POS_W'(1));
  assign cnt_m1 = olte_pkg::ADDR_W'(cnt_r - olte_pkg::CNT_W'(1));

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    iss_nxt    = iss_r;
    pend_nxt   = pend_r;
    plast_nxt  = plast_r;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    ra_nxt     = ra_r;
    rend_nxt   = rend_r;
    pa_nxt     = pa_r;
    down_nxt   = down_r;
    commit_nxt = commit_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    found_nxt  = found_r;
    ram_req    = '0;
    fin        = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt   = in_item.mode;
          pos_nxt    = in_item.position;
          val_nxt    = olte_pkg::WORD_BITS'(in_item.item_value);
          status_nxt = olte_pkg::STAT_OK;
          rd_nxt     = '0;
          found_nxt  = '0;
          commit_nxt = 1'b0;
          iss_nxt    = 1'b0;
          pend_nxt   = 1'b0;
          st_nxt     = ST_FIN;
          unique case (in_item.mode)
            olte_pkg::MODE_INSERT: begin
              if (pos_x == '0 || pos_x > cnt_x + olte_pkg::CMP_W'(1)) begin
                status_nxt = olte_pkg::STAT_RANGE;
              end else if (cnt_r == olte_pkg::CNT_W'(olte_pkg::DEPTH)) begin
                status_nxt = olte_pkg::STAT_FULL;
              end else begin
                commit_nxt = 1'b1;
                if (pos_x <= cnt_x) begin
                  ra_nxt   = cnt_m1;
                  rend_nxt = pos_m1;
                  down_nxt = 1'b1;
                  iss_nxt  = 1'b1;
                  st_nxt   = ST_SCAN;
                end
              end
            end
            olte_pkg::MODE_DELETE, olte_pkg::MODE_GET: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                status_nxt = olte_pkg::STAT_RANGE;
              end else begin
                commit_nxt = (in_item.mode == olte_pkg::MODE_DELETE);
                ra_nxt     = pos_m1;
                rend_nxt   = (in_item.mode == olte_pkg::MODE_DELETE) ? cnt_m1 : pos_m1;
                down_nxt   = 1'b0;
                iss_nxt    = 1'b1;
                st_nxt     = ST_SCAN;
              end
            end
            olte_pkg::MODE_LOCATE: begin
              if (cnt_r != '0) begin
                ra_nxt   = '0;
                rend_nxt = cnt_m1;
                down_nxt = 1'b0;
                iss_nxt  = 1'b1;
                st_nxt   = ST_SCAN;
              end
            end
            olte_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        pend_nxt = 1'b0;
        if (iss_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ra_r;
          pend_nxt      = 1'b1;
          pa_nxt        = ra_r;
          plast_nxt     = (ra_r == rend_r);
          iss_nxt       = (ra_r != rend_r);
          ra_nxt        = down_r ? ra_r - olte_pkg::ADDR_W'(1)
                                 : ra_r + olte_pkg::ADDR_W'(1);
        end
        if (pend_r) begin
          unique case (mode_r)
            olte_pkg::MODE_INSERT: begin
              ram_req.we    = 1'b1;
              ram_req.waddr = pa_r + olte_pkg::ADDR_W'(1);
              ram_req.wdata = ram_rdata;
            end
            olte_pkg::MODE_DELETE: begin
              if (pa_r == olte_pkg::ADDR_W'(pos_r - olte_pkg::POS_W'(1))) begin
                rd_nxt = ram_rdata;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pa_r - olte_pkg::ADDR_W'(1);
                ram_req.wdata = ram_rdata;
              end
            end
            olte_pkg::MODE_LOCATE: begin
              if (ram_rdata == val_r) begin
                found_nxt = olte_pkg::CNT_W'(pa_r) + olte_pkg::CNT_W'(1);
                iss_nxt   = 1'b0;
                pend_nxt  = 1'b0;
                st_nxt    = ST_FIN;
              end
            end
            olte_pkg::MODE_GET: begin
              rd_nxt = ram_rdata;
            end
            default: ;
          endcase
          if (plast_r) begin
            iss_nxt  = 1'b0;
            pend_nxt = 1'b0;
            st_nxt   = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        fin    = 1'b1;
        st_nxt = ST_IDLE;
        if (commit_r) begin
          if (mode_r == olte_pkg::MODE_INSERT) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = olte_pkg::ADDR_W'(pos_r - olte_pkg::POS_W'(1));
            ram_req.wdata = val_r;
            cnt_nxt       = cnt_r + olte_pkg::CNT_W'(1);
          end else begin
            cnt_nxt = cnt_r - olte_pkg::CNT_W'(1);
          end
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      iss_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      iss_r  <= iss_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plast_r  <= plast_nxt;
    mode_r   <= mode_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    ra_r     <= ra_nxt;
    rend_r   <= rend_nxt;
    pa_r     <= pa_nxt;
    down_r   <= down_nxt;
    commit_r <= commit_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    found_r  <= found_nxt;
  end

  assign busy = (st_r != ST_IDLE);

  always_comb begin
    result.status         = status_r;
    result.read_value     = 32'(rd_r);
    result.found_position = olte_pkg::LEN_W'(found_r);
    result.list_length    = olte_pkg::LEN_W'(cnt_nxt);
    result.is_empty       = (cnt_nxt == '0);
  end

endmodule

[rtl/ordered_list_table_engine.sv]
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// Fixed-capacity ordered list with insert, delete, locate, get and clear.
// ----------------------------------------------------------------------------
//  channel  ports                    handshake
//  -------  -----------------------  ---------------------------------------
//  input    start, busy, in_item     item taken on start && !busy
//  result   out_valid, out_item      one-cycle strobe, one result per item
//
//  Insert/delete at p <= n walk entries p to n; locate walks from entry 1 to a match;
//  get reads entry p; append, clear, spare modes, out-of-range and full skip the walk.
//  The store is walked one entry per cycle through its single read port.
//  Reset empties the list; store contents stay undefined until written.
//  The result side cannot stall; busy holds off the next item.
// ----------------------------------------------------------------------------
module ordered_list_table_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  olte_pkg::in_t  in_item,
  output logic           out_valid,
  output olte_pkg::out_t out_item
);

  olte_pkg::ram_req_t ram_req;
  olte_pkg::word_t    ram_rdata;
  olte_pkg::out_t     result;
  logic               fin;
  logic               out_valid_r;
  olte_pkg::out_t     out_item_r;

  olte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .fin       (fin),
    .result    (result),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  olte_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/olte_checker.sv]
// ----------------------------------------------------------------------------
// olte_checker
// Port-level checks for the ordered list table engine.
// ----------------------------------------------------------------------------
module olte_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input olte_pkg::out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but engine not busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("operation ended without a result");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.list_length == '0)))
    else $error("empty flag disagrees with length");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == olte_pkg::STAT_FULL |->
      out_item.list_length == olte_pkg::LEN_W'(olte_pkg::DEPTH))
    else $error("full status with list not full");

endmodule

bind ordered_list_table_engine olte_checker u_olte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[sim/ordered_list_table_engine_tb.sv]
// ----------------------------------------------------------------------------
// ordered_list_table_engine_tb
// Drives list commands through the start/busy port and checks every result
// strobe against a software copy of the list kept in a scoreboard class.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_tb;
  import olte_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
  localparam int         RANDOM_ITEMS   = 1625;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DRAIN_CYCLES   = 80;
  localparam int         REPORT_LIMIT   = 10;

  class list_scoreboard;
    word_t store [DEPTH];
    int    count = 0;
    int    errors = 0;
    out_t  expected_replies [$];

    function word_t pick_stored();
      if (count == 0) return '0;
      return store[$urandom_range(count - 1, 0)];
    endfunction

    function void note_item(in_t it);
      out_t r;
      int   p;
      int   j;
      r = '0;
      p = it.position;
      case (it.mode)
        MODE_INSERT: begin
          if (p < 1 || p > count + 1) begin
            r.status = STAT_RANGE;
          end else if (count >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (j = count; j >= p; j--) store[j] = store[j - 1];
            store[p - 1] = it.item_value;
            count++;
          end
        end
        MODE_DELETE: begin
          if (p < 1 || p > count) begin
            r.status = STAT_RANGE;
          end else begin
            r.read_value = store[p - 1];
            for (j = p; j < count; j++) store[j - 1] = store[j];
            count--;
          end
        end
        MODE_LOCATE: begin
          for (j = 0; j < count; j++) begin
            if (store[j] == it.item_value) begin
              r.found_position = LEN_W'(j + 1);
              break;
            end
          end
        end
        MODE_GET: begin
          if (p < 1 || p > count) r.status = STAT_RANGE;
          else r.read_value = store[p - 1];
        end
        MODE_CLEAR: count = 0;
        default: ;
      endcase
      r.list_length = LEN_W'(count);
      r.is_empty    = (count == 0);
      expected_replies.push_back(r);
    endfunction

    function void report(string what, out_t want, out_t got);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t %s: exp st=%0d rd=%0d fp=%0d len=%0d emp=%0b",
                 $realtime, what, want.status, want.read_value, want.found_position,
                 want.list_length, want.is_empty);
        $display("%0t %s: got st=%0d rd=%0d fp=%0d len=%0d emp=%0b",
                 $realtime, what, got.status, got.read_value, got.found_position,
                 got.list_length, got.is_empty);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_replies.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found_position !== want.found_position ||
          got.list_length !== want.list_length || got.is_empty !== want.is_empty)
        report("mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;
  int   idle_cycles = 0;
  list_scoreboard tracker;

  ordered_list_table_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input in_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_item(it);
  endtask

  task automatic issue(input logic [2:0] mode, input int pos, input word_t val);
    in_t it;
    it.mode       = mode;
    it.position   = POS_W'(pos);
    it.item_value = val;
    send_item(it, 26);
  endtask

  function automatic word_t pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll < 3) return word_t'($signed($urandom_range(4)) - 2);
    if (roll < 4) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    return word_t'($urandom);
  endfunction

  function automatic in_t make_item(input bit growing);
    in_t it;
    int  roll;
    int  n;
    n             = tracker.count;
    roll          = $urandom_range(99);
    it.mode       = MODE_GET;
    it.position   = POS_W'(n == 0 ? 1 : $urandom_range(n, 1));
    it.item_value = pick_value();
    if (roll < 6) begin
      it.mode       = 3'($urandom_range(7));
      it.position   = POS_W'($urandom_range(127));
      it.item_value = word_t'($urandom);
    end else if (roll < 7) begin
      it.mode = MODE_CLEAR;
    end else if (roll < 9) begin
      it.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    end else if (roll < (growing ? 65 : 25)) begin
      it.mode     = MODE_INSERT;
      it.position = POS_W'($urandom_range(n + 1, 1));
    end else if (roll < (growing ? 77 : 70)) begin
      it.mode = MODE_DELETE;
    end else if (roll < (growing ? 88 : 85)) begin
      it.mode = MODE_LOCATE;
      if ($urandom_range(1) == 0) it.item_value = tracker.pick_stored();
    end
    return it;
  endfunction

  initial begin
    bit growing;
    int idle_pct;
    tracker = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners
    issue(MODE_GET,    1,   '0);
    issue(MODE_DELETE, 1,   '0);
    issue(MODE_INSERT, 0,   32'sd7);
    issue(MODE_INSERT, 2,   32'sd7);
    issue(MODE_LOCATE, 0,   '0);
    // front, back and middle inserts with extreme words
    issue(MODE_INSERT, 1,   32'sh7fff_ffff);
    issue(MODE_INSERT, 1,   32'sh8000_0000);
    issue(MODE_INSERT, 3,   '1);
    issue(MODE_INSERT, 2,   '0);
    issue(MODE_LOCATE, 0,   '1);
    issue(MODE_LOCATE, 127, 32'sd12345);
    issue(MODE_GET,    127, '0);
    issue(MODE_GET,    4,   '0);
    issue(MODE_DELETE, 5,   '0);
    issue(MODE_DELETE, 1,   '0);
    issue(MODE_INSERT, 127, '1);
    issue(MODE_SPARE_LO, 127, '1);
    issue(MODE_SPARE_MID, 0, 32'sh5555_aaaa);
    issue(MODE_SPARE_HI, 64, '0);
    issue(MODE_DELETE, 3,   '0);
    issue(MODE_CLEAR,  0,   '0);
    issue(MODE_GET,    1,   '0);
    issue(MODE_INSERT, 1,   32'sd5);
    issue(MODE_INSERT, 2,   32'sd5);
    issue(MODE_LOCATE, 0,   32'sd5);

    growing = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i < RANDOM_ITEMS / 3) ? 26 : (i < 2 * RANDOM_ITEMS / 3) ? 86 : 0;
      send_item(make_item(growing), idle_pct);
      if (tracker.count == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (tracker.count == 0) growing = 1'b1;
      else if ($urandom_range(149) == 0) growing = !growing;
    end
    start <= 1'b0;

    while (tracker.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[files.f]
rtl/olte_pkg.sv
rtl/olte_ram.sv
rtl/olte_ctrl.sv
rtl/ordered_list_table_engine.sv
rtl/olte_checker.sv
sim/ordered_list_table_engine_tb.sv
